>>> design/fmh_pkg.sv
// Shared constants for the floating-point modular hash.
package fmh_pkg;
  localparam int OUT_W = 62;
  localparam int EXP_W = 11;
  localparam int FRAC_W = 52;
  localparam int EXP_BIAS_SHIFT = 1075;
  localparam logic [EXP_W-1:0] EXP_SPECIAL = 11'h7FF;
  localparam logic [OUT_W-1:0] INF_HASH = 62'd314159;
endpackage

>>> design/float_modular_hash.sv
// Top level of the floating-point modular hash.
// Each word is held in the input register, its hash and done in the result register.
// Throughput: one word per cycle; busy is always low and start is taken every cycle.
// The path from the input register to the result register holds the fold, the
// exponent remainder and the rotate; the receiver cannot stall.
// Reset clears only the valid flags; the data registers are not reset.
module float_modular_hash #(
  parameter int HASH_BITS = 61
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [63:0]                 value_bits,
  output logic                        done,
  output logic signed [fmh_pkg::OUT_W-1:0] hash_value
);
  import fmh_pkg::*;

  localparam logic [63:0] MODULUS = (64'd1 << HASH_BITS) - 64'd1;
  localparam int OFFSET = (HASH_BITS - (EXP_BIAS_SHIFT % HASH_BITS)) % HASH_BITS;
  localparam int RSHIFT = 20;
  localparam int RECIP = ((1 << RSHIFT) + HASH_BITS - 1) / HASH_BITS;

  logic        in_valid;
  logic [63:0] in_bits;
  logic        done_reg;
  logic [OUT_W-1:0] hash_reg;
  logic [OUT_W-1:0] hash_next;

  logic             negative;
  logic [EXP_W-1:0] biased;
  logic [FRAC_W-1:0] frac;
  logic [63:0]      sig;
  logic [63:0]      fold1;
  logic [63:0]      fold2;
  logic [63:0]      fold3;
  logic [63:0]      reduced;
  logic [11:0]      exp_adj;
  logic [31:0]      quot_prod;
  logic [11:0]      quot;
  logic [11:0]      rem_raw;
  logic [11:0]      rem_fix;
  logic [5:0]       amt;
  logic [63:0]      mag;
  logic [63:0]      mag_adj;

  assign busy = 1'b0;

  always_comb begin
    negative = in_bits[63];
    biased = in_bits[62:52];
    frac = in_bits[FRAC_W-1:0];
    sig = (biased == '0) ? {12'd0, frac} : {11'd0, 1'b1, frac};
    fold1 = (sig & MODULUS) + (sig >> HASH_BITS);
    fold2 = (fold1 & MODULUS) + (fold1 >> HASH_BITS);
    fold3 = (fold2 & MODULUS) + (fold2 >> HASH_BITS);
    reduced = (fold3 >= MODULUS) ? fold3 - MODULUS : fold3;
    exp_adj = ((biased == '0) ? 12'd1 : {1'b0, biased}) + 12'(OFFSET);
    quot_prod = 32'(exp_adj) * 32'(RECIP);
    quot = 12'(quot_prod >> RSHIFT);
    rem_raw = exp_adj - 12'(quot * 12'(HASH_BITS));
    rem_fix = (rem_raw >= 12'(HASH_BITS)) ? rem_raw - 12'(HASH_BITS) : rem_raw;
    amt = rem_fix[5:0];
    if (amt == '0) begin
      mag = reduced;
    end else begin
      mag = ((reduced << amt) & MODULUS) | (reduced >> (7'(HASH_BITS) - {1'b0, amt}));
    end
    mag_adj = (mag == 64'd1) ? 64'd2 : mag;
    if (biased == EXP_SPECIAL) begin
      if (frac != '0) begin
        hash_next = '0;
      end else begin
        hash_next = negative ? OUT_W'(-INF_HASH) : INF_HASH;
      end
    end else if (negative) begin
      hash_next = OUT_W'(64'd0 - mag_adj);
    end else begin
      hash_next = mag[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done_reg <= 1'b0;
    end else begin
      in_valid <= start;
      done_reg <= in_valid;
    end
    if (start) begin
      in_bits <= value_bits;
    end
    if (in_valid) begin
      hash_reg <= hash_next;
    end
  end

  assign done = done_reg;
  assign hash_value = hash_reg;
endmodule

>>> tb/tb.sv
// Self-checking testbench for the floating-point modular hash.
`timescale 1ns / 100ps
module tb;
  import fmh_pkg::*;

  localparam int HBITS = 61;
  localparam logic [63:0] PRIME = (64'd1 << HBITS) - 64'd1;
  localparam int WATCH_LIMIT = 2000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [63:0] value_bits;
  logic done;
  logic signed [OUT_W-1:0] hash_value;

  logic signed [OUT_W-1:0] pending_hashes[$];
  int fail_count;
  int words_sent;
  int hashes_seen;
  int idle_cycles;
  int send_idle_pct;

  float_modular_hash #(.HASH_BITS(HBITS)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .value_bits(value_bits), .done(done), .hash_value(hash_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] mersenne_fold(logic [63:0] v);
    for (int i = 0; i < 3; i++) v = (v & PRIME) + (v >> HBITS);
    if (v >= PRIME) v = v - PRIME;
    return v;
  endfunction

  function automatic logic signed [OUT_W-1:0] float_hash(logic [63:0] bits);
    logic neg;
    logic [EXP_W-1:0] biased;
    logic [63:0] frac;
    logic [63:0] sig;
    logic [63:0] mag;
    int e2;
    int rot;
    neg = bits[63];
    biased = bits[62:52];
    frac = {12'd0, bits[51:0]};
    if (biased == EXP_SPECIAL) begin
      if (frac != 0) return '0;
      return neg ? -INF_HASH : INF_HASH;
    end
    if (biased == 0) begin
      sig = frac;
      e2 = 1 - EXP_BIAS_SHIFT;
    end else begin
      sig = frac | (64'd1 << 52);
      e2 = int'(biased) - EXP_BIAS_SHIFT;
    end
    rot = e2 % HBITS;
    if (rot < 0) rot += HBITS;
    mag = mersenne_fold(sig);
    if (rot != 0) mag = ((mag << rot) & PRIME) | (mag >> (HBITS - rot));
    if (neg) begin
      if (mag == 1) mag = 2;
      return -mag[OUT_W-1:0];
    end
    return mag[OUT_W-1:0];
  endfunction

  typedef struct {
    logic [63:0] bits;
    logic known;
    logic signed [OUT_W-1:0] hash;
  } stim_row_t;

  stim_row_t directed[] = '{
    '{64'h0000000000000000, 1'b1, 62'sd0},
    '{64'h8000000000000000, 1'b1, 62'sd0},
    '{64'h7FF0000000000000, 1'b1, 62'sd314159},
    '{64'hFFF0000000000000, 1'b1, -62'sd314159},
    '{64'h7FF8000000000000, 1'b1, 62'sd0},
    '{64'hFFFFFFFFFFFFFFFF, 1'b1, 62'sd0},
    '{64'h7FF0000000000001, 1'b1, 62'sd0},
    '{64'h3FF0000000000000, 1'b1, 62'sd1},
    '{64'hBFF0000000000000, 1'b1, -62'sd2},
    '{64'h4000000000000000, 1'b1, 62'sd2},
    '{64'hC000000000000000, 1'b1, -62'sd2},
    '{64'h0000000000000001, 1'b0, 62'sd0},
    '{64'h800FFFFFFFFFFFFF, 1'b0, 62'sd0},
    '{64'h0010000000000000, 1'b0, 62'sd0},
    '{64'h7FEFFFFFFFFFFFFF, 1'b0, 62'sd0},
    '{64'hFFEFFFFFFFFFFFFF, 1'b0, 62'sd0},
    '{64'h43C0000000000000, 1'b0, 62'sd0},
    '{64'h43BFFFFFFFFFFFFF, 1'b0, 62'sd0},
    '{64'h4005555555555555, 1'b0, 62'sd0},
    '{64'hAAAAAAAAAAAAAAAA, 1'b0, 62'sd0},
    '{64'h5555555555555555, 1'b0, 62'sd0}
  };

  function automatic logic [63:0] random_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: w[62:52] = EXP_SPECIAL;
      1: w[62:52] = '0;
      2: w[62:52] = 11'd1023 + 11'($urandom_range(0, 130)) - 11'd65;
      3: w[51:0] = '0;
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_word(logic [63:0] w, logic known, logic signed [OUT_W-1:0] h);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    value_bits <= w;
    pending_hashes.push_back(known ? h : float_hash(w));
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        hashes_seen++;
        if (pending_hashes.size() == 0) begin
          $display("%0t: unexpected word, actual %0d", $time, hash_value);
          fail_count++;
        end else begin
          if (hash_value !== pending_hashes[0]) begin
            $display("%0t: hash mismatch, expected %0d actual %0d",
                     $time, pending_hashes[0], hash_value);
            fail_count++;
          end
          void'(pending_hashes.pop_front());
        end
      end
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("FAIL float_modular_hash");
        $finish;
      end
    end
  end

  initial begin
    int pct[4];
    pct = '{0, 45, 0, 38};
    rst = 1'b1;
    start = 1'b0;
    value_bits = '0;
    fail_count = 0;
    words_sent = 0;
    hashes_seen = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_word(directed[i].bits, directed[i].known, directed[i].hash);
    start <= 1'b0;
    while (pending_hashes.size() != 0) @(negedge clk);
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = pct[p];
      for (int i = 0; i < 450; i++) send_word(random_word(), 1'b0, '0);
    end
    start <= 1'b0;
    while (pending_hashes.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    $display("Sent %0d words: zeros, infinities, NaNs, subnormals, normals,", words_sent);
    $display("with sender gaps of 0, 45 and 38 percent; %0d hashes checked.", hashes_seen);
    if (fail_count == 0 && pending_hashes.size() == 0) begin
      $display("PASS float_modular_hash");
    end else begin
      $display("FAIL float_modular_hash");
    end
    $finish;
  end
endmodule

>>> float_modular_hash.f
design/fmh_pkg.sv
design/float_modular_hash.sv
tb/tb.sv
